// File: sv/bhg_pkg.sv
// Package with shared constants and types for the homomorphic Butterworth gain block.
package bhg_pkg;

    localparam int WORK_BITS = 31;
    localparam int FRAC_BITS = 16;
    localparam int MAX_ORDER = 8;
    localparam int OUT_W     = 19;
    localparam int DIM_W     = 13;
    localparam int IDX_W     = 12;
    localparam int ORD_W     = 4;
    localparam int GAIN_W    = 9;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_W  = 64;
    localparam int DEN_W  = 33;
    localparam int QUO_W  = 32;
    localparam int STEPS  = QUO_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOW   = 3'd5;

    localparam logic [DIM_W-1:0]  RST_FRAME_ROWS = 13'd1024;
    localparam logic [DIM_W-1:0]  RST_FRAME_COLS = 13'd1024;
    localparam logic [DIM_W-1:0]  RST_CUTOFF     = 13'd10;
    localparam logic [ORD_W-1:0]  RST_ORDER      = 4'd2;
    localparam logic [GAIN_W-1:0] RST_GAIN_HIGH  = 9'd120;
    localparam logic [GAIN_W-1:0] RST_GAIN_LOW   = 9'd80;

    // Final scaling by 1/(100 << (WORK_BITS - FRAC_BITS)) is a shift and a division by 25.
    localparam int          SCALE_SHIFT = WORK_BITS - FRAC_BITS + 2;
    localparam int          SCALE_DIV   = 25;
    localparam logic [41:0] SCALE_HALF  = 42'(100) << (WORK_BITS - FRAC_BITS - 1);
    localparam int          RECIP_SHIFT = 28;
    localparam logic [23:0] RECIP_MUL   = 24'((64'd1 << RECIP_SHIFT) / SCALE_DIV);

    typedef struct packed {
        logic s_zero;
        logic s_ge;
    } side_t;

endpackage

// File: sv/butterworth_homomorphic_gain.sv
// Top level of the homomorphic Butterworth gain pipeline.
//
//  Channel   Signals                               Direction
//  input     in_valid, in_ready, row_index, col_index   in
//  output    out_valid, out_ready, gain_q16            out
//  config    cfg_we, cfg_index, cfg_data               in
//
// One transaction is accepted per cycle while the output is not stalled; each result passes
// through 79 register stages: the two 33-stage dividers, the eight power stages and five
// further stages.
// Reset clears all valid bits and loads the default register values.
// A stall on the output holds the whole pipeline, so nothing is lost or repeated.
module butterworth_homomorphic_gain (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bhg_pkg::IDX_W-1:0]         row_index,
    input  logic [bhg_pkg::IDX_W-1:0]         col_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bhg_pkg::OUT_W-1:0]         gain_q16,
    input  logic                              cfg_we,
    input  logic [bhg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bhg_pkg::DIM_W-1:0]         cfg_data
);

    localparam int WB = bhg_pkg::WORK_BITS;
    localparam int NP = bhg_pkg::MAX_ORDER;

    logic [bhg_pkg::DIM_W-1:0]  frame_rows_reg;
    logic [bhg_pkg::DIM_W-1:0]  frame_cols_reg;
    logic [bhg_pkg::DIM_W-1:0]  cutoff_reg;
    logic [bhg_pkg::ORD_W-1:0]  order_reg;
    logic [bhg_pkg::GAIN_W-1:0] gain_high_reg;
    logic [bhg_pkg::GAIN_W-1:0] gain_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= bhg_pkg::RST_FRAME_ROWS;
            frame_cols_reg <= bhg_pkg::RST_FRAME_COLS;
            cutoff_reg     <= bhg_pkg::RST_CUTOFF;
            order_reg      <= bhg_pkg::RST_ORDER;
            gain_high_reg  <= bhg_pkg::RST_GAIN_HIGH;
            gain_low_reg   <= bhg_pkg::RST_GAIN_LOW;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bhg_pkg::REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                bhg_pkg::REG_FRAME_COLS: frame_cols_reg <= cfg_data;
                bhg_pkg::REG_CUTOFF:     cutoff_reg     <= cfg_data;
                bhg_pkg::REG_ORDER:      order_reg      <= cfg_data[bhg_pkg::ORD_W-1:0];
                bhg_pkg::REG_GAIN_HIGH:  gain_high_reg  <= cfg_data[bhg_pkg::GAIN_W-1:0];
                bhg_pkg::REG_GAIN_LOW:   gain_low_reg   <= cfg_data[bhg_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    logic [bhg_pkg::OUT_W-1:0] gain_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    logic [bhg_pkg::ORD_W-1:0] n_eff;
    assign n_eff = (order_reg > bhg_pkg::ORD_W'(NP)) ? bhg_pkg::ORD_W'(NP) : order_reg;

    // Distances from the centre.
    logic [bhg_pkg::IDX_W-1:0] c_row, c_col, dr_next, dc_next;
    logic [bhg_pkg::IDX_W-1:0] dr_reg, dc_reg;
    logic                      v1_reg;

    assign c_row   = frame_rows_reg[bhg_pkg::DIM_W-1:1];
    assign c_col   = frame_cols_reg[bhg_pkg::DIM_W-1:1];
    assign dr_next = (row_index >= c_row) ? row_index - c_row : c_row - row_index;
    assign dc_next = (col_index >= c_col) ? col_index - c_col : c_col - col_index;

    // Squared distance and squared cutoff.
    logic [24:0] s_reg;
    logic [25:0] d2_reg;
    logic        v2_reg;
    logic [25:0] s_ext, lo, hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dr_reg <= dr_next;
            dc_reg <= dc_next;
            s_reg  <= 25'(24'(dr_reg) * 24'(dr_reg)) + 25'(24'(dc_reg) * 24'(dc_reg));
            d2_reg <= 26'(cutoff_reg) * 26'(cutoff_reg);
        end
    end

    assign s_ext = {1'b0, s_reg};
    assign lo    = (s_ext < d2_reg) ? s_ext : d2_reg;
    assign hi    = (s_ext < d2_reg) ? d2_reg : s_ext;

    bhg_pkg::side_t side_a;
    assign side_a.s_zero = (s_reg == '0);
    assign side_a.s_ge   = (s_ext >= d2_reg);

    logic                         x_valid;
    logic [bhg_pkg::QUO_W-1:0]    x_quo;
    bhg_pkg::side_t               x_side;

    bhg_div u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .num       (bhg_pkg::NUM_W'(lo) << WB),
        .den       (bhg_pkg::DEN_W'(hi)),
        .side_in   (side_a),
        .out_valid (x_valid),
        .quo       (x_quo),
        .side_out  (x_side)
    );

    // Power stages: stage k multiplies when k is below the order.
    logic [31:0]    p_reg    [0:NP-1];
    logic [31:0]    xp_reg   [0:NP-1];
    bhg_pkg::side_t ps_reg   [0:NP-1];
    logic           pv_reg   [0:NP-1];
    logic [31:0]    p_next   [0:NP-1];

    always_comb
    begin
        logic [63:0] prod;
        logic [31:0] p_in;
        logic [31:0] x_in;
        for (int k = 0; k < NP; k++)
        begin
            p_in = (k == 0) ? (32'd1 << WB) : p_reg[(k == 0) ? 0 : k-1];
            x_in = (k == 0) ? x_quo : xp_reg[(k == 0) ? 0 : k-1];
            prod = 64'(p_in) * 64'(x_in) + (64'd1 << (WB - 1));
            p_next[k] = (bhg_pkg::ORD_W'(k) < n_eff) ? prod[WB+31:WB] : p_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NP; k++)
            begin
                pv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            pv_reg[0] <= x_valid;
            for (int k = 1; k < NP; k++)
            begin
                pv_reg[k] <= pv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0]  <= p_next[0];
            xp_reg[0] <= x_quo;
            ps_reg[0] <= x_side;
            for (int k = 1; k < NP; k++)
            begin
                p_reg[k]  <= p_next[k];
                xp_reg[k] <= xp_reg[k-1];
                ps_reg[k] <= ps_reg[k-1];
            end
        end
    end

    // Fraction 1/(1+(d2/s)^n), formed as 1/(1+q^n) or q^n/(1+q^n) from the ratio q.
    logic [bhg_pkg::DEN_W-1:0] f_den;
    logic [bhg_pkg::NUM_W-1:0] f_num;

    assign f_den = (bhg_pkg::DEN_W'(1) << WB) + bhg_pkg::DEN_W'(p_reg[NP-1]);
    assign f_num = (ps_reg[NP-1].s_ge ? (bhg_pkg::NUM_W'(1) << (2 * WB))
                                      : (bhg_pkg::NUM_W'(p_reg[NP-1]) << WB))
                   + bhg_pkg::NUM_W'(f_den >> 1);

    logic                      f_valid;
    logic [bhg_pkg::QUO_W-1:0] f_quo;
    bhg_pkg::side_t            f_side;

    bhg_div u_div_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pv_reg[NP-1]),
        .num       (f_num),
        .den       (f_den),
        .side_in   (ps_reg[NP-1]),
        .out_valid (f_valid),
        .quo       (f_quo),
        .side_out  (f_side)
    );

    // Blend of the gains, then scaling to the output format.
    logic [31:0] f_eff;
    logic [41:0] v_next, t_full;
    logic [41:0] v_reg;
    logic        vv_reg;
    logic [23:0] t_reg;
    logic [47:0] m_reg;
    logic        vm_reg;
    logic [23:0] q0, q_fix, rem;

    assign f_eff = f_side.s_zero ? '0 : f_quo;

    always_comb
    begin
        logic [41:0] base;
        logic [41:0] delta;
        base = 42'(gain_low_reg) << WB;
        if (gain_high_reg >= gain_low_reg)
        begin
            delta  = 42'(gain_high_reg - gain_low_reg) * 42'(f_eff);
            v_next = base + delta;
        end
        else
        begin
            delta  = 42'(gain_low_reg - gain_high_reg) * 42'(f_eff);
            v_next = base - delta;
        end
    end

    assign t_full = (v_reg + bhg_pkg::SCALE_HALF) >> bhg_pkg::SCALE_SHIFT;

    assign q0    = 24'(m_reg >> bhg_pkg::RECIP_SHIFT);
    assign rem   = t_reg - 24'(q0 * 24'(bhg_pkg::SCALE_DIV));
    assign q_fix = (rem >= 24'(bhg_pkg::SCALE_DIV)) ? q0 + 24'd1 : q0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vv_reg        <= f_valid;
            vm_reg        <= vv_reg;
            out_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg    <= v_next;
            t_reg    <= t_full[23:0];
            m_reg    <= 48'(t_full[23:0]) * 48'(bhg_pkg::RECIP_MUL);
            gain_reg <= (q_fix > 24'({bhg_pkg::OUT_W{1'b1}})) ? {bhg_pkg::OUT_W{1'b1}}
                                                               : q_fix[bhg_pkg::OUT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign gain_q16  = gain_reg;

endmodule

// File: sv/bhg_div.sv
// Pipelined restoring divider: an input register, then one quotient bit per register stage.
module bhg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [bhg_pkg::NUM_W-1:0]     num,
    input  logic [bhg_pkg::DEN_W-1:0]     den,
    input  bhg_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [bhg_pkg::QUO_W-1:0]     quo,
    output bhg_pkg::side_t                side_out
);

    localparam int S = bhg_pkg::STEPS;
    localparam int DW = bhg_pkg::DEN_W;
    localparam int QW = bhg_pkg::QUO_W;

    logic                valid_reg [0:S];
    logic [DW-1:0]       rem_reg   [0:S];
    logic [QW-1:0]       low_reg   [0:S];
    logic [QW-1:0]       quo_reg   [0:S];
    logic [DW-1:0]       den_reg   [0:S];
    bhg_pkg::side_t      side_reg  [0:S];

    logic [DW-1:0]       rem_next  [1:S];
    logic [QW-1:0]       quo_next  [1:S];

    always_comb
    begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        for (int k = 1; k <= S; k++)
        begin
            trial = {rem_reg[k-1], low_reg[k-1][QW-1]};
            diff  = trial - {1'b0, den_reg[k-1]};
            ge    = (trial >= {1'b0, den_reg[k-1]});
            rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next[k] = {quo_reg[k-1][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= S; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= {1'b0, num[bhg_pkg::NUM_W-1:QW]};
            low_reg[0]  <= num[QW-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int k = 1; k <= S; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= {low_reg[k-1][QW-2:0], 1'b0};
                quo_reg[k]  <= quo_next[k];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[S];
    assign quo       = quo_reg[S];
    assign side_out  = side_reg[S];

endmodule
